FILE: rtl/core/htc_pkg.sv
`default_nettype none
package htc_pkg;

    localparam int FRACTION_BITS = 16;
    localparam int WORD_W        = 32;
    localparam int WORDS         = 9;
    localparam int MAX_VERTS     = 10;
    localparam int DIST_W        = WORD_W + 2;
    localparam int T_W           = FRACTION_BITS + 1;
    localparam int EPS_W         = 16;

    typedef logic [WORDS-1:0][WORD_W-1:0] t_vtx;
    typedef logic [3:0]                   t_cnt;
    typedef logic [2:0]                   t_plane;
    typedef logic [1:0]                   t_slot;

    localparam t_cnt   MAX_CNT    = t_cnt'(MAX_VERTS);
    localparam t_cnt   TRI_CNT    = 4'd3;
    localparam t_slot  LAST_SLOT  = 2'd2;

    localparam t_plane PL_W       = 3'd0;
    localparam t_plane PL_XR      = 3'd1;
    localparam t_plane PL_XL      = 3'd2;
    localparam t_plane PL_YT      = 3'd3;
    localparam t_plane PL_YB      = 3'd4;
    localparam t_plane PL_ZN      = 3'd5;
    localparam t_plane PL_ZF      = 3'd6;
    localparam t_plane LAST_PLANE = PL_ZF;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PSTART,
        S_LDPREV,
        S_RDCUR,
        S_EVAL,
        S_DECIDE,
        S_DIV,
        S_LERP,
        S_WRLERP,
        S_COPY,
        S_NEXT,
        S_PEND,
        S_OUTRD,
        S_OUTLD,
        S_OUTWAIT,
        S_EMPTY
    } t_state;

    typedef struct packed {
        logic   ld_in;
        logic   rd;
        logic   rd_b;
        t_cnt   rd_addr;
        logic   wr_b;
        t_cnt   wr_addr;
        logic   ld_prev;
        logic   ld_cur;
        logic   shift_prev;
        logic   div_start;
        logic   lerp_start;
        logic   wr_lerp;
        logic   wr_cur;
        logic   out_ld;
        logic   out_last;
        logic   out_none;
        t_plane plane;
    } t_dp_cmd;

    typedef struct packed {
        logic cin;
        logic pin;
        logic div_idle;
        logic lerp_done;
    } t_dp_stat;

    function automatic logic signed [DIST_W-1:0] plane_dist(
        input t_plane pl, input t_vtx v, input logic [EPS_W-1:0] eps);
        logic signed [DIST_W-1:0] w;
        logic signed [DIST_W-1:0] x;
        logic signed [DIST_W-1:0] y;
        logic signed [DIST_W-1:0] z;
        logic signed [DIST_W-1:0] e;
        logic signed [DIST_W-1:0] d;
        w = DIST_W'($signed(v[3]));
        x = DIST_W'($signed(v[0]));
        y = DIST_W'($signed(v[1]));
        z = DIST_W'($signed(v[2]));
        e = $signed({{(DIST_W-EPS_W){1'b0}}, eps});
        case (pl)
            PL_W:    d = w + e;
            PL_XR:   d = w - x;
            PL_XL:   d = w + x;
            PL_YT:   d = w - y;
            PL_YB:   d = w + y;
            PL_ZN:   d = w - z;
            default: d = w + z;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/htc_ctrl.sv
`default_nettype none
module htc_ctrl
    import htc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_out_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output logic          o_in_ready,
    output logic          o_out_valid
);

    t_state r_state, n_state;
    t_slot  r_slot;
    t_cnt   r_n, r_m, r_i, r_k;
    t_plane r_plane;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (i_in_valid && r_slot == LAST_SLOT) n_state = S_PSTART;
            S_PSTART:  n_state = (r_n == '0) ? S_PEND : S_LDPREV;
            S_LDPREV:  n_state = S_RDCUR;
            S_RDCUR:   n_state = S_EVAL;
            S_EVAL:    n_state = S_DECIDE;
            S_DECIDE: begin
                if (i_stat.cin != i_stat.pin && r_m < MAX_CNT) n_state = S_DIV;
                else if (i_stat.cin && r_m < MAX_CNT)        n_state = S_COPY;
                else                                         n_state = S_NEXT;
            end
            S_DIV:     if (i_stat.div_idle) n_state = S_LERP;
            S_LERP:    if (i_stat.lerp_done) n_state = S_WRLERP;
            S_WRLERP:  n_state = (i_stat.cin && r_m < MAX_CNT - 4'd1) ? S_COPY : S_NEXT;
            S_COPY:    n_state = S_NEXT;
            S_NEXT:    n_state = (r_i + 4'd1 == r_n) ? S_PEND : S_RDCUR;
            S_PEND: begin
                if (r_plane == LAST_PLANE) n_state = (r_m == '0) ? S_EMPTY : S_OUTRD;
                else                       n_state = S_PSTART;
            end
            S_OUTRD:   n_state = S_OUTLD;
            S_OUTLD:   n_state = S_OUTWAIT;
            S_OUTWAIT: begin
                if (i_out_ready) begin
                    n_state = ({1'b0, r_k} + 5'd1 >= {1'b0, r_n}) ? S_IDLE : S_OUTRD;
                end
            end
            S_EMPTY:   n_state = S_OUTWAIT;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.plane = r_plane;
        o_cmd.rd_b  = r_plane[0];
        o_cmd.wr_b  = ~r_plane[0];
        o_cmd.wr_addr = r_m;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.ld_in   = i_in_valid;
                o_cmd.wr_b    = 1'b0;
                o_cmd.wr_addr = t_cnt'(r_slot);
            end
            S_PSTART: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_addr = r_n - 4'd1;
            end
            S_LDPREV:  o_cmd.ld_prev = 1'b1;
            S_RDCUR: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_addr = r_i;
            end
            S_EVAL:    o_cmd.ld_cur = 1'b1;
            S_DECIDE:  o_cmd.div_start = (i_stat.cin != i_stat.pin) && (r_m < MAX_CNT);
            S_DIV:     o_cmd.lerp_start = i_stat.div_idle;
            S_WRLERP:  o_cmd.wr_lerp = 1'b1;
            S_COPY:    o_cmd.wr_cur = 1'b1;
            S_NEXT:    o_cmd.shift_prev = 1'b1;
            S_OUTRD: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_b    = 1'b1;
                o_cmd.rd_addr = r_k;
            end
            S_OUTLD: begin
                o_cmd.out_ld   = 1'b1;
                o_cmd.out_last = (r_k + 4'd1 == r_n);
            end
            S_OUTWAIT: o_out_valid = 1'b1;
            S_EMPTY: begin
                o_cmd.out_ld   = 1'b1;
                o_cmd.out_last = 1'b1;
                o_cmd.out_none = 1'b1;
            end
            default: o_cmd.plane = r_plane;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_n     <= '0;
            r_m     <= '0;
            r_i     <= '0;
            r_k     <= '0;
            r_plane <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (r_slot == LAST_SLOT) begin
                            r_slot  <= '0;
                            r_n     <= TRI_CNT;
                            r_plane <= PL_W;
                        end else begin
                            r_slot <= r_slot + 2'd1;
                        end
                    end
                end
                S_PSTART: begin
                    r_m <= '0;
                    r_i <= '0;
                end
                S_WRLERP, S_COPY: r_m <= r_m + 4'd1;
                S_NEXT:   r_i <= r_i + 4'd1;
                S_PEND: begin
                    r_n     <= r_m;
                    r_plane <= r_plane + 3'd1;
                    r_k     <= '0;
                end
                S_OUTWAIT: if (i_out_ready) r_k <= r_k + 4'd1;
                default: r_k <= r_k;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/htc_datapath.sv
`default_nettype none
module htc_datapath
    import htc_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_dp_cmd          i_cmd,
    input  wire t_vtx             i_vtx,
    input  wire logic [EPS_W-1:0] i_eps,
    output t_dp_stat              o_stat,
    output t_vtx                  o_vtx,
    output logic                  o_last,
    output logic                  o_none
);

    localparam int NUM_W   = DIST_W;
    localparam int DEN_W   = DIST_W + 1;
    localparam int REM_W   = DEN_W + 1;
    localparam int DCNT_W  = $clog2(T_W + 1);
    localparam int WIDX_W  = $clog2(WORDS);
    localparam int DIFF_W  = WORD_W + 1;
    localparam int PROD_W  = DIFF_W + T_W + 1;
    localparam int SUM_W   = PROD_W + 1;
    localparam logic [T_W-1:0]    T_ONE     = {1'b1, {FRACTION_BITS{1'b0}}};
    localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(T_W);
    localparam logic [WIDX_W-1:0] LAST_WORD = WIDX_W'(WORDS - 1);

    t_vtx r_mem_a [MAX_VERTS];
    t_vtx r_mem_b [MAX_VERTS];
    t_vtx r_rdata, r_prev, r_cur, r_new, r_out;
    logic signed [DIST_W-1:0] r_dp, r_dc;
    logic r_pin, r_cin, r_last, r_none;

    logic [REM_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_du;
    logic [T_W-1:0]    r_q;
    logic [DCNT_W-1:0] r_dcnt;

    logic [WIDX_W-1:0]        r_lj, r_pj;
    logic                     r_lact, r_pv;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [WORD_W-1:0] r_pa;

    logic signed [DIST_W-1:0] rd_dist;
    logic signed [DEN_W-1:0]  den;
    logic [NUM_W-1:0]         nu;
    logic [DEN_W-1:0]         du;
    logic                     wr_any;
    t_vtx                     wdata;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-1:0]  sum;
    logic [WORD_W-1:0]        sat;

    assign rd_dist = plane_dist(i_cmd.plane, r_rdata, i_eps);
    assign den     = DEN_W'(r_dp) - DEN_W'(r_dc);
    assign nu      = r_dp[DIST_W-1] ? NUM_W'(-r_dp) : NUM_W'(r_dp);
    assign du      = den[DEN_W-1] ? DEN_W'(-den) : DEN_W'(den);
    assign wr_any  = i_cmd.ld_in || i_cmd.wr_lerp || i_cmd.wr_cur;
    assign wdata   = i_cmd.ld_in ? i_vtx : (i_cmd.wr_lerp ? r_new : r_cur);

    assign diff = DIFF_W'($signed(r_cur[r_lj])) - DIFF_W'($signed(r_prev[r_lj]));
    assign sum  = SUM_W'(r_prod >>> FRACTION_BITS) + SUM_W'(r_pa);

    always_comb begin
        if (sum[SUM_W-1] && !(&sum[SUM_W-1:WORD_W-1])) begin
            sat = {1'b1, {(WORD_W-1){1'b0}}};
        end else if (!sum[SUM_W-1] && (|sum[SUM_W-2:WORD_W-1])) begin
            sat = {1'b0, {(WORD_W-1){1'b1}}};
        end else begin
            sat = sum[WORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_any && !i_cmd.wr_b) r_mem_a[i_cmd.wr_addr] <= wdata;
        if (wr_any && i_cmd.wr_b)  r_mem_b[i_cmd.wr_addr] <= wdata;
        if (i_cmd.rd) r_rdata <= i_cmd.rd_b ? r_mem_b[i_cmd.rd_addr] : r_mem_a[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin <= 1'b0;
            r_cin <= 1'b0;
        end else if (i_cmd.ld_prev) begin
            r_pin <= rd_dist[DIST_W-1] || (rd_dist == '0);
        end else if (i_cmd.ld_cur) begin
            r_cin <= rd_dist[DIST_W-1] || (rd_dist == '0);
        end else if (i_cmd.shift_prev) begin
            r_pin <= r_cin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_prev) begin
            r_prev <= r_rdata;
            r_dp   <= rd_dist;
        end else if (i_cmd.shift_prev) begin
            r_prev <= r_cur;
            r_dp   <= r_dc;
        end
        if (i_cmd.ld_cur) begin
            r_cur <= r_rdata;
            r_dc  <= rd_dist;
        end
        if (i_cmd.out_ld) begin
            r_out <= i_cmd.out_none ? '0 : r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last <= 1'b0;
            r_none <= 1'b0;
        end else if (i_cmd.out_ld) begin
            r_last <= i_cmd.out_last;
            r_none <= i_cmd.out_none;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.div_start) begin
            if (du == '0 || {1'b0, nu} > du) begin
                r_q    <= T_ONE;
                r_dcnt <= '0;
            end else begin
                r_rem  <= REM_W'(nu);
                r_du   <= du;
                r_q    <= '0;
                r_dcnt <= DIV_STEPS;
            end
        end else if (r_dcnt != '0) begin
            if (r_rem >= {1'b0, r_du}) begin
                r_q   <= {r_q[T_W-2:0], 1'b1};
                r_rem <= (r_rem - {1'b0, r_du}) << 1;
            end else begin
                r_q   <= {r_q[T_W-2:0], 1'b0};
                r_rem <= r_rem << 1;
            end
            r_dcnt <= r_dcnt - DCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lact <= 1'b0;
            r_pv   <= 1'b0;
            r_lj   <= '0;
            r_pj   <= '0;
        end else begin
            r_pv <= r_lact;
            if (i_cmd.lerp_start) begin
                r_lact <= 1'b1;
                r_lj   <= '0;
            end else if (r_lact) begin
                r_pj <= r_lj;
                r_lj <= r_lj + WIDX_W'(1);
                if (r_lj == LAST_WORD) r_lact <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_lact) begin
            r_prod <= diff * $signed({1'b0, r_q});
            r_pa   <= $signed(r_prev[r_lj]);
        end
        if (r_pv) r_new[r_pj] <= sat;
    end

    assign o_stat.cin       = r_cin;
    assign o_stat.pin       = r_pin;
    assign o_stat.div_idle  = (r_dcnt == '0);
    assign o_stat.lerp_done = r_pv && (r_pj == LAST_WORD);
    assign o_vtx  = r_out;
    assign o_last = r_last;
    assign o_none = r_none;

endmodule
`default_nettype wire

FILE: rtl/core/homogeneous_triangle_clipper_unit.sv
// The first two vertices of a triangle are only stored.
// After the third vertex, seven plane passes run over the polygon; each crossing edge
// uses a 17-step divider and a 9-word shared multiplier. Each result is read from the
// buffer, then held on the output until it is accepted.
// One triangle is processed at a time; the next vertex is taken after the last result.
// Synchronous active-low reset clears the controller and sets w_epsilon to 66.
`default_nettype none
module homogeneous_triangle_clipper_unit
    import htc_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // clip_x, clip_y, clip_z, clip_w, world_x, world_y, world_z, tex_u, tex_v
    input  wire logic [287:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // out_clip_x, out_clip_y, out_clip_z, out_clip_w, out_world_x, out_world_y,
    // out_world_z, out_tex_u, out_tex_v
    output logic [287:0]      m_axis_tdata,
    output logic              m_axis_tlast,
    // none_left
    output logic              m_axis_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam logic [EPS_W-1:0] EPS_RESET = 16'd66;
    localparam logic             REG_EPS   = 1'b0;

    logic [EPS_W-1:0] r_w_epsilon;
    t_dp_cmd          cmd;
    t_dp_stat         stat;
    t_vtx             out_vtx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_epsilon <= EPS_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_EPS) begin
            r_w_epsilon <= pwdata[EPS_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_EPS) ? {{(32-EPS_W){1'b0}}, r_w_epsilon} : '0;

    htc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    htc_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_vtx   (t_vtx'(s_axis_tdata)),
        .i_eps   (r_w_epsilon),
        .o_stat  (stat),
        .o_vtx   (out_vtx),
        .o_last  (m_axis_tlast),
        .o_none  (m_axis_tuser)
    );

    assign m_axis_tdata = 288'(out_vtx);

endmodule
`default_nettype wire
